// ===== rtl/kfr_pkg.sv =====
// Shared types and constants of the keyed FIFO with removal.
// Depends on nothing; kfr_scan, the core, the checker and the testbench import it.
package kfr_pkg;

	localparam int DEPTH = 16;
	localparam int KEY_W = 32;
	localparam int OCC_W = 5;
	localparam int ST_W  = 3;
	localparam int CMD_W = 2;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(DEPTH);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 2'd0,
		CMD_SERVE  = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_COUNT  = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_RESP
	} state_t;

	// Sequencer to scan unit.
	typedef struct packed {
		logic             start;
		logic             run;
		logic [CNT_W-1:0] base;
	} scan_ctl_t;

	// Scan unit to sequencer.
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic             done;
		logic [CNT_W-1:0] idx;
	} scan_st_t;

endpackage

// ===== rtl/kfr_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module kfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/kfr_scan.sv =====
// Scan unit: walks the occupied slots one read a cycle and compares each
// returned entry to the held key. Depends on kfr_pkg.
module kfr_scan (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kfr_pkg::scan_ctl_t              ctl,
	input  logic [kfr_pkg::CNT_W-1:0]       fill,
	input  logic [kfr_pkg::KEY_W-1:0]       key,
	input  logic [kfr_pkg::KEY_W-1:0]       rdata,
	output logic                            re,
	output logic [kfr_pkg::IDX_W-1:0]       raddr,
	output kfr_pkg::scan_st_t               st
);
	import kfr_pkg::*;

	logic [CNT_W-1:0] scan_q;
	logic             vld_s1;
	logic [CNT_W-1:0] idx_s1;
	logic             issue;

	// issue a read while slots remain below the fill level
	assign issue = ctl.run && (scan_q < fill);
	assign re    = issue;
	assign raddr = scan_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			vld_s1 <= 1'b0;
		end else if (ctl.start) begin
			scan_q <= ctl.base;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
	end

	always_comb begin
		st.vld  = vld_s1;
		st.idx  = idx_s1;
		st.hit  = vld_s1 && (rdata == key);
		st.done = ctl.run && !vld_s1 && (scan_q >= fill);
	end
endmodule

// ===== rtl/keyed_fifo_with_removal_core.sv =====
// Top level of the keyed FIFO with removal: sequencer, fill count, result
// register. Depends on kfr_pkg, kfr_ram and kfr_scan.
//   Command channel (in_valid/in_ready, cmd, key) takes one command at a
//   time: enqueue, serve oldest, remove by key, or count query. Result
//   channel (out_valid/out_ready, status, out_key, occupancy) returns
//   exactly one result per command, in command order.
//   Keys live in a 16-entry RAM, oldest in slot 0. One scan unit with a
//   single 32-bit comparator reads one slot per cycle; it serves both the
//   key search and the shift that closes the gap left by a removed key.
//   Count query and empty serve/remove go straight to the result; enqueue
//   without a duplicate and absent-key remove search every held slot;
//   serve shifts all held slots one down; a remove that finds its key at
//   position p searches up to p, then shifts the slots above p down.
//   Each walk is paced by the one-read-per-cycle RAM port.
//   in_ready is high only while the sequencer is idle, so the next command
//   is taken as soon as the last one's result is loaded, even while that
//   result still waits in the output register. If the receiver stalls, the
//   result holds and a further finished result waits in the sequencer.
//   Reset empties the queue (fill count zero) and clears out_valid; the
//   RAM is not cleared, only slots below the fill count are ever read.
module keyed_fifo_with_removal_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [kfr_pkg::CMD_W-1:0]         cmd,
	input  logic signed [kfr_pkg::KEY_W-1:0]  key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [kfr_pkg::ST_W-1:0]          status,
	output logic signed [kfr_pkg::KEY_W-1:0]  out_key,
	output logic [kfr_pkg::OCC_W-1:0]         occupancy
);
	import kfr_pkg::*;

	state_t                 state_q, state_d;
	cmd_t                   cmd_q;
	cmd_t                   cmd_in;
	logic [KEY_W-1:0]       key_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CNT_W-1:0]       pos_q;
	status_t                res_st_q;
	logic [KEY_W-1:0]       res_key_q;

	logic                   out_valid_q;
	status_t                status_q;
	logic [KEY_W-1:0]       out_key_q;
	logic [OCC_W-1:0]       occ_q;

	scan_ctl_t              scan_ctl;
	scan_st_t               scan_st;
	logic                   ram_re;
	logic [IDX_W-1:0]       ram_raddr;
	logic [KEY_W-1:0]       ram_rdata;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [KEY_W-1:0]       ram_wdata;

	logic                   accept;
	logic                   is_empty;
	logic                   is_full;
	logic                   out_free;
	logic [CNT_W-1:0]       sh_dst;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	assign cmd_in   = cmd_t'(cmd);
	assign accept   = in_valid && in_ready;
	assign is_empty = (fill_q == '0);
	assign is_full  = (fill_q == FILL_MAX);
	assign out_free = !out_valid_q || out_ready;
	// shifted entry lands one slot below the slot it was read from
	assign sh_dst   = scan_st.idx - CNT_W'(1);
	assign occ_ext  = {{OCC_W{1'b0}}, fill_q};

	kfr_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	kfr_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (scan_ctl),
		.fill  (fill_q),
		.key   (key_q),
		.rdata (ram_rdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.st    (scan_st)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_in)
						CMD_ENQ:    state_d = S_SEARCH;
						CMD_SERVE:  state_d = is_empty ? S_RESP : S_SHIFT;
						CMD_REMOVE: state_d = is_empty ? S_RESP : S_SEARCH;
						CMD_COUNT:  state_d = S_RESP;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_SEARCH: begin
				if (scan_st.hit) begin
					state_d = (cmd_q == CMD_REMOVE) ? S_SHIFT : S_RESP;
				end else if (scan_st.done) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (scan_st.done) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, scan control, RAM write port.
	always_comb begin
		in_ready      = 1'b0;
		scan_ctl      = '0;
		ram_we        = 1'b0;
		ram_waddr     = fill_q[IDX_W-1:0];
		ram_wdata     = key_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready       = 1'b1;
				scan_ctl.start = accept;
			end
			S_SEARCH: begin
				scan_ctl.run = 1'b1;
				if (scan_st.hit && cmd_q == CMD_REMOVE) begin
					// restart the walk at the match to close the gap
					scan_ctl.start = 1'b1;
					scan_ctl.base  = scan_st.idx;
				end else if (scan_st.done && cmd_q == CMD_ENQ && !is_full) begin
					ram_we = 1'b1;
				end
			end
			S_SHIFT: begin
				scan_ctl.run = 1'b1;
				if (scan_st.vld && scan_st.idx != pos_q) begin
					ram_we    = 1'b1;
					ram_waddr = sh_dst[IDX_W-1:0];
					ram_wdata = ram_rdata;
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SEARCH && scan_st.done && cmd_q == CMD_ENQ && !is_full) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (state_q == S_SHIFT && scan_st.done) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Command, working result and output payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q     <= cmd_in;
					key_q     <= key;
					pos_q     <= '0;
					res_key_q <= '0;
					if ((cmd_in == CMD_SERVE || cmd_in == CMD_REMOVE) && is_empty) begin
						res_st_q <= ST_EMPTY;
					end else begin
						res_st_q <= ST_OK;
					end
				end
			end
			S_SEARCH: begin
				if (scan_st.hit) begin
					if (cmd_q == CMD_REMOVE) begin
						pos_q <= scan_st.idx;
					end else begin
						res_st_q <= ST_DUP;
					end
				end else if (scan_st.done) begin
					if (cmd_q == CMD_REMOVE) begin
						res_st_q <= ST_NOTFOUND;
					end else if (is_full) begin
						res_st_q <= ST_FULL;
					end
				end
			end
			S_SHIFT: begin
				// first read of the walk returns the entry being dropped
				if (scan_st.vld && scan_st.idx == pos_q) begin
					res_key_q <= ram_rdata;
				end
			end
			S_RESP: begin
				if (out_free) begin
					status_q  <= res_st_q;
					out_key_q <= res_key_q;
					occ_q     <= occ_ext[OCC_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign occupancy = occ_q;
endmodule

// ===== rtl/kfr_checker.sv =====
// Port-level checks for the keyed FIFO with removal, bound to the top level.
// Depends on kfr_pkg and keyed_fifo_with_removal_core.
module kfr_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [kfr_pkg::CMD_W-1:0]         cmd,
	input logic signed [kfr_pkg::KEY_W-1:0]  key,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [kfr_pkg::ST_W-1:0]          status,
	input logic signed [kfr_pkg::KEY_W-1:0]  out_key,
	input logic [kfr_pkg::OCC_W-1:0]         occupancy
);
	import kfr_pkg::*;

	// one command at a time: a transfer closes the command port
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command port still open after a transfer");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(out_key) && $stable(occupancy))
		else $error("stalled result changed");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> occupancy == '0 && out_key == '0)
		else $error("empty status with keys or a key");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> occupancy == OCC_FULL && out_key == '0)
		else $error("full status with wrong occupancy");

	a_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUP || status == ST_NOTFOUND) |-> out_key == '0)
		else $error("key returned on a failed command");
endmodule

bind keyed_fifo_with_removal_core kfr_checker u_kfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.cmd      (cmd),
	.key      (key),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.out_key  (out_key),
	.occupancy(occupancy)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for keyed_fifo_with_removal_core: directed and random commands
// checked against a queue-based scoreboard. Depends on kfr_pkg and the RTL.
module tb;
	import kfr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 3 * (2 * DEPTH + 5);
	localparam int PHASE_ITEMS  = 130;
	localparam int KEY_POOL     = 24;

	// One expected result transfer.
	typedef struct {
		status_t            status;
		logic [KEY_W-1:0]   key;
		logic [OCC_W-1:0]   occ;
	} fifo_result_t;

	// Tracks queue contents and the results still owed by the block.
	class key_queue_tracker;
		logic [KEY_W-1:0] held_keys[$];
		fifo_result_t     pending_results[$];
		int               mismatches;

		function int find_slot(logic [KEY_W-1:0] k);
			foreach (held_keys[i])
				if (held_keys[i] == k)
					return i;
			return -1;
		endfunction

		// Apply one accepted command and queue the result it must produce.
		function void note_command(cmd_t c, logic [KEY_W-1:0] k);
			fifo_result_t r;
			int           pos;
			r.status = ST_OK;
			r.key    = '0;
			pos      = find_slot(k);
			case (c)
				CMD_ENQ: begin
					// duplicate check wins over the full check
					if (pos >= 0)
						r.status = ST_DUP;
					else if (held_keys.size() >= DEPTH)
						r.status = ST_FULL;
					else
						held_keys.insert(held_keys.size(), k);
				end
				CMD_SERVE: begin
					if (held_keys.size() == 0)
						r.status = ST_EMPTY;
					else begin
						r.key = held_keys[0];
						held_keys.delete(0);
					end
				end
				CMD_REMOVE: begin
					if (held_keys.size() == 0)
						r.status = ST_EMPTY;
					else if (pos < 0)
						r.status = ST_NOTFOUND;
					else begin
						r.key = held_keys[pos];
						held_keys.delete(pos);
					end
				end
				default: ;
			endcase
			r.occ = OCC_W'(held_keys.size());
			pending_results.insert(pending_results.size(), r);
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic [KEY_W-1:0] k,
				logic [OCC_W-1:0] occ);
			fifo_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d key %h occupancy %0d",
						st, k, occ);
				return;
			end
			want = pending_results[0];
			pending_results.delete(0);
			if (st !== want.status || k !== want.key || occ !== want.occ) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: want st %0d key %h occ %0d, got st %0d key %h occ %0d",
						want.status, want.key, want.occ, st, k, occ);
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		function int held_count();
			return held_keys.size();
		endfunction

		function logic [KEY_W-1:0] any_held_key();
			return held_keys[$urandom_range(held_keys.size() - 1)];
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [KEY_W-1:0]  key;
	logic                     out_valid;
	logic                     out_ready;
	logic [ST_W-1:0]          status;
	logic signed [KEY_W-1:0]  out_key;
	logic [OCC_W-1:0]         occupancy;

	key_queue_tracker tracker = new();
	logic [KEY_W-1:0] key_pool[KEY_POOL];
	int               send_idle_pct;
	int               recv_stall_pct;

	keyed_fifo_with_removal_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_key   (out_key),
		.occupancy (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: pick out_ready at each falling edge from the current stall rate.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every result transfer against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(status, out_key, occupancy);
	end

	// Hard stop in case the block hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("keyed_fifo_with_removal_core verification failed");
		$finish;
	end

	// Present one command and hold it until the transfer. Idle cycles go in
	// front of the command, with valid low, at the current idle rate.
	task automatic send_cmd(cmd_t c, logic [KEY_W-1:0] k);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd      = c;
		key      = k;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_command(c, k);
	endtask

	// Favor keys that are queued or drawn from a small fixed pool so duplicates
	// and removal hits are common; add a fully random key now and then.
	function automatic logic [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40 && tracker.held_count() > 0)
			return tracker.any_held_key();
		if (roll < 85)
			return key_pool[$urandom_range(KEY_POOL - 1)];
		return $urandom();
	endfunction

	task automatic run_directed();
		// empty queue: count, serve and remove all see nothing
		send_cmd(CMD_COUNT, 32'h0000_0000);
		send_cmd(CMD_SERVE, 32'h5A5A_5A5A);
		send_cmd(CMD_REMOVE, 32'h8000_0000);
		// extreme keys
		send_cmd(CMD_ENQ, 32'h8000_0000);
		send_cmd(CMD_ENQ, 32'h7FFF_FFFF);
		send_cmd(CMD_ENQ, 32'h0000_0000);
		send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
		send_cmd(CMD_ENQ, 32'h7FFF_FFFF);
		send_cmd(CMD_REMOVE, 32'h7FFF_FFFE);
		// remove from the middle, then serve the oldest
		send_cmd(CMD_REMOVE, 32'h0000_0000);
		send_cmd(CMD_SERVE, 32'h0000_0000);
		// fill to capacity
		for (int i = 0; i < DEPTH - 2; i++)
			send_cmd(CMD_ENQ, 32'h00A5_0000 | i);
		send_cmd(CMD_ENQ, 32'h1234_5678);
		// duplicate on a full queue reports duplicate, not full
		send_cmd(CMD_ENQ, 32'hFFFF_FFFF);
		// remove the youngest and the oldest slot
		send_cmd(CMD_REMOVE, 32'h00A5_0000 | (DEPTH - 3));
		send_cmd(CMD_REMOVE, 32'h7FFF_FFFF);
		send_cmd(CMD_COUNT, 32'hFFFF_FFFF);
	endtask

	// Random commands in stretches of 40 that lean toward filling or draining,
	// so the queue swings between empty and full.
	task automatic run_random(int items);
		int   roll;
		cmd_t c;
		bit   filling;
		filling = 1'b1;
		for (int n = 0; n < items; n++) begin
			if (n % 40 == 0)
				filling = 1'($urandom_range(1));
			roll = $urandom_range(99);
			if (roll < (filling ? 55 : 20))
				c = CMD_ENQ;
			else if (roll < (filling ? 72 : 55))
				c = CMD_SERVE;
			else if (roll < 92)
				c = CMD_REMOVE;
			else
				c = CMD_COUNT;
			send_cmd(c, pick_key());
		end
	endtask

	initial begin
		int idle_mix[4];
		int stall_mix[4];
		idle_mix  = '{0, 55, 0, 15};
		stall_mix = '{0, 0, 55, 15};
		// Drive every input to a known value before anything else.
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = CMD_COUNT;
		key            = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (key_pool[i])
			key_pool[i] = $urandom();

		// Hold reset, then release it away from the rising edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();

		// Advance through the idle/stall phases.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = idle_mix[p];
			recv_stall_pct = stall_mix[p];
			run_random(PHASE_ITEMS);
		end

		// Drop valid after the last transfer and drain the result channel.
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0)
			$display("keyed_fifo_with_removal_core verification clean");
		else
			$display("keyed_fifo_with_removal_core verification failed");
		$finish;
	end

endmodule
